// ----- hdl/sem_pkg.sv -----
// Package for the Sobel edge magnitude block: sizes, state codes, pixel helpers.
// No dependencies; every other file imports it.
package sem_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int DIM_W      = 11;
	localparam int ROW_W      = 11;
	localparam int PIX_W      = 24;
	localparam int GRAD_W     = 12;
	localparam int SQ_W       = 21;
	localparam int IDX_W      = 8;
	localparam logic [SQ_W-1:0] SQ_SAT = SQ_W'(64771);

	localparam logic [IDX_W-1:0] REG_WIDTH  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_HEIGHT = IDX_W'(1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CALC,
		S_SQR,
		S_START,
		S_WAIT
	} state_t;

	function automatic logic [7:0] chan(input logic [PIX_W-1:0] px, input int unsigned ch);
		chan = px[8*ch +: 8];
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] hi);
		if (v == '0) begin
			clamp_dim = DIM_W'(1);
		end else if (v > hi) begin
			clamp_dim = hi;
		end else begin
			clamp_dim = v;
		end
	endfunction

endpackage

// ----- hdl/sem_line_store.sv -----
// Two line buffers of the Sobel block packed into one synchronous memory word.
// Depends on sem_pkg; read data is registered.
module sem_line_store
	import sem_pkg::*;
(
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [COL_W-1:0]     rd_addr,
	output logic [2*PIX_W-1:0]   rd_data,
	input  logic                 wr_en,
	input  logic [COL_W-1:0]     wr_addr,
	input  logic [2*PIX_W-1:0]   wr_data
);

	logic [2*PIX_W-1:0] mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hdl/sem_sqrt.sv -----
// Iterative rounded, saturating square root: one result bit per cycle.
// Depends on sem_pkg.
module sem_sqrt
	import sem_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [SQ_W-1:0] sq,
	output logic            fin,
	output logic [7:0]      root
);

	logic [SQ_W-1:0] s_q;
	logic [7:0]      r_q;
	logic [2:0]      step_q;
	logic            busy_q;
	logic            fin_q;
	logic [7:0]      t;
	logic [15:0]     tt;
	logic [16:0]     rr;

	assign t  = r_q | (8'd1 << step_q);
	assign tt = 16'(t) * 16'(t);
	assign rr = 17'(16'(r_q) * 16'(r_q)) + 17'(r_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			fin_q  <= 1'b0;
			step_q <= 3'd7;
		end else if (busy_q) begin
			step_q <= step_q - 3'd1;
			if (step_q == 3'd0) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			s_q <= sq;
			r_q <= '0;
		end else if (busy_q && SQ_W'(tt) <= s_q) begin
			r_q <= t;
		end
	end

	// round to nearest: bump when s lies above r*r+r
	always_comb begin
		if (s_q >= SQ_SAT) begin
			root = 8'd255;
		end else if (s_q > SQ_W'(rr)) begin
			root = r_q + 8'd1;
		end else begin
			root = r_q;
		end
	end

	assign fin = fin_q;

endmodule

// ----- hdl/sobel_edge_magnitude_rgb.sv -----
// Top level of the streaming 3x3 Sobel edge magnitude block for RGB pixels.
// Depends on sem_pkg, sem_line_store and sem_sqrt.
//
// Usage:
//   Input channel (in_valid / in_stall): one item per handshake, raster order.
//   mode 0 carries a pixel, mode 1 is a drain step that pushes out results
//   once the last pixel of the frame is in. The result for a pixel leaves
//   on the item accepted image_width+1 positions later; frame_end marks the
//   frame's last pixel, and the item after it starts a new frame.
//   Output channel (out_valid / out_stall): zero or one item per input item,
//   held in an output register while the receiver stalls.
//   Configuration (cfg_valid / cfg_ready): index 0 is image_width, index 1
//   image_height, clamped to 1..1024; a write to either restarts the frame.
//   Flow: items are handled one at a time. An item that yields no result
//   passes the line store read, then the update; one with a result then
//   also passes the square stage and the 8-step iterative square root unit.
//   A finished result waits in the output register, and the next item is
//   taken while it waits. Reset sets both sizes to 1024 and starts a frame;
//   line store reads in a frame's first row return unwritten data, used only in blanked rows.
module sobel_edge_magnitude_rgb
	import sem_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             mode,
	input  logic [7:0]       red_in,
	input  logic [7:0]       green_in,
	input  logic [7:0]       blue_in,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       red_out,
	output logic [7:0]       green_out,
	output logic [7:0]       blue_out,
	output logic             frame_end,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0] cfg_data
);

	state_t state_q, state_n;

	logic [DIM_W-1:0] w_q, h_q;
	logic [COL_W-1:0] ic_q, ic_eff;
	logic [ROW_W-1:0] ir_q;
	logic [PIX_W-1:0] win_q [6];   // columns 0 and 1 of the window, oldest first
	logic [PIX_W-1:0] pix_q;

	logic             accept, cfg_wr, out_free, load_out;
	logic             upd, rd_en;
	logic [2*PIX_W-1:0] rd_data;
	logic [PIX_W-1:0] ncol [3];
	logic [PIX_W-1:0] nb [3][3];
	logic             have, fe;
	logic [ROW_W-1:0] orow;
	logic [DIM_W-1:0] ocol;
	logic [DIM_W-1:0] ic_next;

	logic signed [GRAD_W-1:0] gx_c [3], gy_c [3];
	logic signed [GRAD_W-1:0] gx_q [3], gy_q [3];
	logic [SQ_W-1:0]          sq_q [3];
	logic                     fe_q;
	logic                     start;
	logic [2:0]               fin;
	logic [7:0]               root [3];
	logic                     out_valid_q;

	assign accept   = in_valid && !in_stall;
	assign cfg_wr   = cfg_valid && cfg_ready;
	assign out_free = !out_valid_q || !out_stall;
	assign ic_eff   = (DIM_W'(ic_q) >= w_q) ? '0 : ic_q;

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE:  if (accept) state_n = S_CALC;
			S_CALC:  state_n = have ? S_SQR : S_IDLE;
			S_SQR:   state_n = S_START;
			S_START: state_n = S_WAIT;
			S_WAIT:  if (&fin && out_free) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		rd_en     = 1'b0;
		upd       = 1'b0;
		start     = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall  = 1'b0;
				cfg_ready = 1'b1;
				rd_en     = in_valid;
			end
			S_CALC:  upd = 1'b1;
			S_START: start = 1'b1;
			S_WAIT:  load_out = &fin && out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	sem_line_store u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (ic_eff),
		.rd_data (rd_data),
		.wr_en   (upd),
		.wr_addr (ic_eff),
		.wr_data ({rd_data[PIX_W-1:0], pix_q})
	);

	// hold the pixel, blacked out for drain steps and rows past the frame
	always_ff @(posedge clk) begin
		if (accept) begin
			if (!mode && ir_q < ROW_W'(h_q)) begin
				pix_q <= {red_in, green_in, blue_in};
			end else begin
				pix_q <= '0;
			end
		end
	end

	// neighborhood and output position
	always_comb begin
		ncol[0] = rd_data[2*PIX_W-1:PIX_W];
		ncol[1] = rd_data[PIX_W-1:0];
		ncol[2] = pix_q;
		if (ic_eff != '0) begin
			have = ir_q >= ROW_W'(1) && (ir_q - ROW_W'(1)) < ROW_W'(h_q);
			orow = ir_q - ROW_W'(1);
			ocol = DIM_W'(ic_eff) - DIM_W'(1);
		end else begin
			have = ir_q >= ROW_W'(2) && (ir_q - ROW_W'(2)) < ROW_W'(h_q);
			orow = ir_q - ROW_W'(2);
			ocol = w_q - DIM_W'(1);
		end
		fe = orow == ROW_W'(h_q - DIM_W'(1)) && ocol == w_q - DIM_W'(1);
		for (int r = 0; r < 3; r++) begin
			nb[r][0] = win_q[r];
			nb[r][1] = win_q[3+r];
			nb[r][2] = (ic_eff != '0) ? ncol[r] : '0;
			if (ocol == '0) nb[r][0] = '0;
			if (ocol == w_q - DIM_W'(1)) nb[r][2] = '0;
		end
		for (int c = 0; c < 3; c++) begin
			if (orow == '0) nb[0][c] = '0;
			if (orow == ROW_W'(h_q - DIM_W'(1))) nb[2][c] = '0;
		end
	end

	// gradients, one lane per color channel (lane 0 is blue)
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			gx_c[ch] = (GRAD_W'(chan(nb[0][2], ch)) + (GRAD_W'(chan(nb[1][2], ch)) <<< 1)
				+ GRAD_W'(chan(nb[2][2], ch)))
				- (GRAD_W'(chan(nb[0][0], ch)) + (GRAD_W'(chan(nb[1][0], ch)) <<< 1)
				+ GRAD_W'(chan(nb[2][0], ch)));
			gy_c[ch] = (GRAD_W'(chan(nb[2][0], ch)) + (GRAD_W'(chan(nb[2][1], ch)) <<< 1)
				+ GRAD_W'(chan(nb[2][2], ch)))
				- (GRAD_W'(chan(nb[0][0], ch)) + (GRAD_W'(chan(nb[0][1], ch)) <<< 1)
				+ GRAD_W'(chan(nb[0][2], ch)));
		end
	end

	assign ic_next = DIM_W'(ic_eff) + DIM_W'(1);

	// sizes, raster position and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q  <= DIM_W'(MAX_WIDTH);
			h_q  <= DIM_W'(MAX_HEIGHT);
			ic_q <= '0;
			ir_q <= '0;
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (cfg_wr) begin
			if (cfg_index == REG_WIDTH) begin
				w_q <= clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
			end
			if (cfg_index == REG_HEIGHT) begin
				h_q <= clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));
			end
			if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT) begin
				ic_q <= '0;
				ir_q <= '0;
				for (int i = 0; i < 6; i++) win_q[i] <= '0;
			end
		end else if (upd) begin
			if (have && fe) begin
				// restart the frame after its last result
				ic_q <= '0;
				ir_q <= '0;
				for (int i = 0; i < 6; i++) win_q[i] <= '0;
			end else begin
				for (int r = 0; r < 3; r++) begin
					win_q[r]   <= win_q[3+r];
					win_q[3+r] <= ncol[r];
				end
				if (ic_next >= w_q) begin
					ic_q <= '0;
					if (12'(ir_q) <= 12'(h_q) + 12'd1) ir_q <= ir_q + ROW_W'(1);
				end else begin
					ic_q <= ic_next[COL_W-1:0];
				end
			end
		end
	end

	// gradient and square stages
	always_ff @(posedge clk) begin
		if (upd) begin
			gx_q <= gx_c;
			gy_q <= gy_c;
			fe_q <= fe;
		end
		if (state_q == S_SQR) begin
			for (int ch = 0; ch < 3; ch++) begin
				sq_q[ch] <= SQ_W'((2*GRAD_W)'(gx_q[ch] * gx_q[ch])
					+ (2*GRAD_W)'(gy_q[ch] * gy_q[ch]));
			end
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_root
		sem_sqrt u_sqrt (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (start),
			.sq     (sq_q[ch]),
			.fin    (fin[ch]),
			.root   (root[ch])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			red_out   <= root[2];
			green_out <= root[1];
			blue_out  <= root[0];
			frame_end <= fe_q;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_accept_calc: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_CALC)
		else $error("accepted item did not reach the update step");
	a_start_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_START |=> state_q == S_WAIT && fin == 3'b000)
		else $error("square root did not start");
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		12'(ir_q) <= 12'(h_q) + 12'd2)
		else $error("input row ran past its bound");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while stalled");
`endif

endmodule
